// ----- hdl/sbpf_pkg.sv -----
// Shared types and constants for the servo bus packet framer.
`default_nettype none

package sbpf_pkg;

   // Default depth of the command queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Reset values of the configuration registers.
   localparam logic [7:0] START_BYTE_RESET  = 8'd255;
   localparam logic [7:0] BROADCAST_RESET   = 8'd254;
   localparam logic [7:0] SYNC_OPCODE_RESET = 8'd131;
   localparam logic       TWO_BYTE_RESET    = 1'b1;

   // Configuration register indexes (byte address divided by four).
   localparam logic [1:0] REG_START_BYTE  = 2'd0;
   localparam logic [1:0] REG_BROADCAST   = 2'd1;
   localparam logic [1:0] REG_SYNC_OPCODE = 2'd2;
   localparam logic [1:0] REG_TWO_BYTE    = 2'd3;

   // Length offsets of the two header kinds.
   localparam logic [7:0] PLAIN_LEN_OFFSET = 8'd3;
   localparam logic [7:0] SYNC_LEN_OFFSET  = 8'd4;

   // Function codes of an input transaction.
   typedef enum logic [1:0] {
      FUNC_PLAIN_HDR = 2'd0,
      FUNC_PARAM     = 2'd1,
      FUNC_SYNC_HDR  = 2'd2,
      FUNC_ENTRY     = 2'd3
   } func_type;

   // Classified command kinds handed from front to back.
   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_SYNC  = 3'd1,
      KIND_PARAM = 3'd2,
      KIND_ENTRY = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   // One queued command.
   typedef struct packed {
      kind_type    kind;
      logic        last;
      logic [7:0]  dev_id;
      logic [7:0]  instruction;
      logic [7:0]  start_address;
      logic [7:0]  entry_length;
      logic [7:0]  len_byte;
      logic [15:0] value;
   } cmd_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] broadcast_id;
      logic [7:0] sync_opcode;
      logic       two_byte;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hdl/sbpf_front.sv -----
// Front end: accepts input transactions, tracks packet phase and classifies them.
`default_nettype none

module sbpf_front
   import sbpf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_dev_id,
   input  wire logic [7:0]  req_instruction,
   input  wire logic [7:0]  req_start_address,
   input  wire logic [7:0]  req_item_count,
   input  wire logic [7:0]  req_entry_length,
   input  wire logic [15:0] req_value,
   input  wire logic        q_full,
   output logic             q_push,
   output cmd_type          q_cmd
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PLAIN = 2'd1,
      PH_SYNC  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic       accept;
   logic [7:0] rem_dec;
   logic [7:0] elen_p1;
   logic [15:0] sync_prod;
   logic [7:0] plain_len;
   logic [7:0] sync_len;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;

   // Length bytes of both header kinds, taken modulo 256.
   assign rem_dec   = remaining_ff - 8'd1;
   assign elen_p1   = req_entry_length + 8'd1;
   assign sync_prod = elen_p1 * req_item_count;
   assign plain_len = req_item_count + PLAIN_LEN_OFFSET;
   assign sync_len  = sync_prod[7:0] + SYNC_LEN_OFFSET;

   // Classify the transaction against the current packet phase.
   always_comb begin
      q_cmd.kind          = KIND_ERROR;
      q_cmd.last          = 1'b0;
      q_cmd.dev_id        = req_dev_id;
      q_cmd.instruction   = req_instruction;
      q_cmd.start_address = req_start_address;
      q_cmd.entry_length  = req_entry_length;
      q_cmd.len_byte      = plain_len;
      q_cmd.value         = req_value;
      phase_in            = phase_ff;
      remaining_in        = remaining_ff;
      case (func_type'(req_func))
         FUNC_PLAIN_HDR: begin
            if (phase_ff == PH_IDLE) begin
               q_cmd.kind   = KIND_PLAIN;
               q_cmd.last   = (req_item_count == 8'd0);
               remaining_in = req_item_count;
               phase_in     = q_cmd.last ? PH_IDLE : PH_PLAIN;
            end
         end
         FUNC_SYNC_HDR: begin
            if (phase_ff == PH_IDLE) begin
               q_cmd.kind     = KIND_SYNC;
               q_cmd.len_byte = sync_len;
               q_cmd.last     = (req_item_count == 8'd0);
               remaining_in   = req_item_count;
               phase_in       = q_cmd.last ? PH_IDLE : PH_SYNC;
            end
         end
         FUNC_PARAM: begin
            if (phase_ff == PH_PLAIN) begin
               q_cmd.kind   = KIND_PARAM;
               q_cmd.last   = (rem_dec == 8'd0);
               remaining_in = rem_dec;
               phase_in     = q_cmd.last ? PH_IDLE : PH_PLAIN;
            end
         end
         FUNC_ENTRY: begin
            if (phase_ff == PH_SYNC) begin
               q_cmd.kind   = KIND_ENTRY;
               q_cmd.last   = (rem_dec == 8'd0);
               remaining_in = rem_dec;
               phase_in     = q_cmd.last ? PH_IDLE : PH_SYNC;
            end
         end
         default: begin
            q_cmd.kind = KIND_ERROR;
         end
      endcase
   end

   // Phase and remaining count advance only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sbpf_queue.sv -----
// Small command queue that decouples the front end from the byte sequencer.
`default_nettype none

module sbpf_queue
   import sbpf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         full,
   output logic         not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sbpf_back.sv -----
// Back end: walks each queued command byte by byte and keeps the running checksum.
`default_nettype none

module sbpf_back
   import sbpf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire cmd_type head_cmd,
   input  wire logic    q_not_empty,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_packet_end,
   output logic         rsp_order_error
);

   cmd_type    cur_ff;
   logic       cur_valid_ff;
   logic [2:0] step_ff;
   logic [7:0] sum_ff, sum_in;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       err_ff;

   logic       advance;
   logic       is_header;
   logic [2:0] last_idx;
   logic       final_step;
   logic       chk_step;
   logic       summed;
   logic [7:0] data_byte;
   logic [7:0] out_byte;

   assign advance    = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_header  = (cur_ff.kind == KIND_PLAIN) || (cur_ff.kind == KIND_SYNC);
   assign final_step = (step_ff == last_idx);
   assign chk_step   = final_step && cur_ff.last && (cur_ff.kind != KIND_ERROR);
   assign q_pop      = q_not_empty && (!cur_valid_ff || (advance && final_step));

   // Index of the final byte of the current command.
   always_comb begin
      case (cur_ff.kind)
         KIND_PLAIN: last_idx = cur_ff.last ? 3'd6 : 3'd5;
         KIND_SYNC:  last_idx = cur_ff.last ? 3'd7 : 3'd6;
         KIND_PARAM: last_idx = cur_ff.last ? 3'd1 : 3'd0;
         KIND_ENTRY: last_idx = {2'b00, cfg.two_byte} + {2'b00, cur_ff.last} + 3'd1;
         default:    last_idx = 3'd0;
      endcase
   end

   // Packet byte for the current step, before the checksum override.
   always_comb begin
      data_byte = 8'd0;
      case (cur_ff.kind)
         KIND_PLAIN: begin
            case (step_ff)
               3'd0, 3'd1: data_byte = cfg.start_byte;
               3'd2:       data_byte = cur_ff.dev_id;
               3'd3:       data_byte = cur_ff.len_byte;
               3'd4:       data_byte = cur_ff.instruction;
               default:    data_byte = cur_ff.start_address;
            endcase
         end
         KIND_SYNC: begin
            case (step_ff)
               3'd0, 3'd1: data_byte = cfg.start_byte;
               3'd2:       data_byte = cfg.broadcast_id;
               3'd3:       data_byte = cur_ff.len_byte;
               3'd4:       data_byte = cfg.sync_opcode;
               3'd5:       data_byte = cur_ff.start_address;
               default:    data_byte = cur_ff.entry_length;
            endcase
         end
         KIND_PARAM: data_byte = cur_ff.value[7:0];
         KIND_ENTRY: begin
            case (step_ff)
               3'd0:    data_byte = cur_ff.dev_id;
               3'd1:    data_byte = cur_ff.value[7:0];
               default: data_byte = cur_ff.value[15:8];
            endcase
         end
         default: data_byte = 8'd0;
      endcase
   end

   assign out_byte = chk_step ? ~sum_ff : data_byte;
   assign summed   = !chk_step && (cur_ff.kind != KIND_ERROR) &&
                     !(is_header && (step_ff < 3'd2));

   // Running sum: cleared at a packet's first start byte and after its checksum.
   always_comb begin
      sum_in = sum_ff;
      if (advance) begin
         if (chk_step || (is_header && (step_ff == 3'd0))) begin
            sum_in = 8'd0;
         end else if (summed) begin
            sum_in = sum_ff + data_byte;
         end
      end
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
         sum_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            step_ff      <= 3'd0;
         end else if (advance) begin
            if (final_step) begin
               cur_valid_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= head_cmd;
      end
      if (advance) begin
         byte_ff <= out_byte;
         end_ff  <= chk_step;
         err_ff  <= (cur_ff.kind == KIND_ERROR);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_packet_end  = end_ff;
   assign rsp_order_error = err_ff;

endmodule

`default_nettype wire

// ----- hdl/servo_bus_packet_framer_unit.sv -----
// Path: an accepted transaction goes through the command queue and the back end's
// current-command register before its first byte is registered at the output.
// The sequencer sends one byte per cycle while the output is not stalled, one to eight
// bytes per transaction; the queue lets the front take one per cycle until it is full.
// Reset (synchronous, active high) clears the packet phase, the queue, the checksum and
// the output valid flag, and restores the configuration registers to their defaults.
`default_nettype none

module servo_bus_packet_framer_unit
   import sbpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_dev_id,
   input  wire logic [7:0]  req_instruction,
   input  wire logic [7:0]  req_start_address,
   input  wire logic [7:0]  req_item_count,
   input  wire logic [7:0]  req_entry_length,
   input  wire logic [15:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_packet_end,
   output logic             rsp_order_error,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type cfg_ff;
   logic    cfg_write;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_not_empty;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= START_BYTE_RESET;
         cfg_ff.broadcast_id <= BROADCAST_RESET;
         cfg_ff.sync_opcode  <= SYNC_OPCODE_RESET;
         cfg_ff.two_byte     <= TWO_BYTE_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_START_BYTE:  cfg_ff.start_byte   <= pwdata[7:0];
            REG_BROADCAST:   cfg_ff.broadcast_id <= pwdata[7:0];
            REG_SYNC_OPCODE: cfg_ff.sync_opcode  <= pwdata[7:0];
            REG_TWO_BYTE:    cfg_ff.two_byte     <= pwdata[0];
            default:         cfg_ff.two_byte     <= cfg_ff.two_byte;
         endcase
      end
   end

   // Configuration register reads.
   always_comb begin
      case (paddr[3:2])
         REG_START_BYTE:  prdata = {24'd0, cfg_ff.start_byte};
         REG_BROADCAST:   prdata = {24'd0, cfg_ff.broadcast_id};
         REG_SYNC_OPCODE: prdata = {24'd0, cfg_ff.sync_opcode};
         REG_TWO_BYTE:    prdata = {31'd0, cfg_ff.two_byte};
         default:         prdata = 32'd0;
      endcase
   end

   sbpf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_dev_id        (req_dev_id),
      .req_instruction   (req_instruction),
      .req_start_address (req_start_address),
      .req_item_count    (req_item_count),
      .req_entry_length  (req_entry_length),
      .req_value         (req_value),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   sbpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .head_cmd  (head_cmd),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   sbpf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_cmd        (head_cmd),
      .q_not_empty     (q_not_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_order_error (rsp_order_error)
   );

endmodule

`default_nettype wire

// ----- hdl/sbpf_checker.sv -----
// Port-level checks on the packet framer and the bind that attaches them.
`default_nettype none

module sbpf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_packet_end,
   input wire logic       rsp_order_error
);

   // No result transaction is offered in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result transaction holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_packet_end) && $stable(rsp_order_error)))
      else $error("stalled result changed");

   // A dropped transaction never closes a packet.
   a_err_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_order_error && rsp_packet_end))
      else $error("error result marked as packet end");

   // An error result carries a zero byte.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_order_error) |-> (rsp_out_byte == 8'd0))
      else $error("error result with nonzero byte");

endmodule

bind servo_bus_packet_framer_unit sbpf_checker u_sbpf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_packet_end  (rsp_packet_end),
   .rsp_order_error (rsp_order_error)
);

`default_nettype wire
